/* design/idll_pkg.sv */
// Shared types and constants for the indexed doubly linked list block.
// Holds field widths, operation codes and status codes; no dependencies.
package idll_pkg;

    localparam int ID_W        = 10;
    localparam int OP_W        = 2;
    localparam int ST_W        = 3;
    localparam int ENTRIES_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_INS_LEFT  = 2'd0,
        OP_INS_RIGHT = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_FOLLOW    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK            = 3'd0,
        ST_ANCHOR_ABSENT = 3'd1,
        ST_ITEM_PRESENT  = 3'd2,
        ST_ITEM_ABSENT   = 3'd3,
        ST_ITEM_ZERO     = 3'd4
    } t_status;

endpackage

/* design/idll_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module idll_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/indexed_doubly_linked_list_top.sv */
// Top level of the indexed doubly linked list block.
// Depends on idll_pkg and idll_ram (successor, predecessor and present tables).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per
//   transaction: insert left, insert right, remove or follow, with an item id
//   and an anchor id. Output channel (o_out_valid / i_out_stall) returns one
//   status and the neighbour ids for every accepted transaction, in order.
//   A small sequencer drives one read address shared by the three tables
//   and one write port per table; the block takes one transaction at a time.
//   Sequence: the key entry is read on acceptance, S_RDI reads the item entry,
//   S_DEC sets the status and makes the first writes of a successful remove or
//   insert, S_WR2 writes the neighbour links of a successful insert, and
//   S_DONE loads the output register; a new transaction waits for S_IDLE.
//   Reset: a clearing pass rewrites the successor, predecessor and present
//   tables and leaves only the sentinel and member 1 in the list; o_in_stall
//   stays high during the pass. A result held under i_out_stall keeps its
//   payload; the next transaction may be accepted meanwhile and waits for the
//   output register before it finishes.
module indexed_doubly_linked_list_top #(
    parameter int ENTRIES = idll_pkg::ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [idll_pkg::OP_W-1:0] i_operation,
    input  logic [idll_pkg::ID_W-1:0] i_item_id,
    input  logic [idll_pkg::ID_W-1:0] i_anchor_id,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [idll_pkg::ST_W-1:0] o_status,
    output logic [idll_pkg::ID_W-1:0] o_next_id,
    output logic [idll_pkg::ID_W-1:0] o_prev_id
);

    import idll_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RDI   = 6'b000100,
        S_DEC   = 6'b001000,
        S_WR2   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_cnt;
    t_op           r_op;
    logic [ID_W-1:0] r_item, r_anchor;
    logic [ID_W-1:0] r_key_succ, r_key_pred;
    logic            r_key_pres;
    t_status         r_res_status, n_res_status;
    logic [ID_W-1:0] r_res_next, n_res_next, r_res_prev, n_res_prev;
    logic            r_out_valid;
    logic [ST_W-1:0] r_out_status;
    logic [ID_W-1:0] r_out_next, r_out_prev;

    logic            in_accept, out_load;
    logic [ID_W-1:0] in_key, key_id, pv, nx;
    logic            key_in, item_in, key_member;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            succ_we, pred_we, pres_we;
    logic [AW-1:0]   succ_waddr, pred_waddr, pres_waddr;
    logic [ID_W-1:0] succ_wdata, pred_wdata, succ_q, pred_q;
    logic            pres_wdata, pres_q;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign in_key     = (t_op'(i_operation) == OP_REMOVE) ? i_item_id : i_anchor_id;
    assign key_id     = (r_op == OP_REMOVE) ? r_item : r_anchor;
    assign key_in     = 32'(key_id) < ENTRIES;
    assign item_in    = 32'(r_item) < ENTRIES;
    assign key_member = key_in && r_key_pres;
    assign pv         = (r_op == OP_INS_LEFT) ? r_key_pred : r_anchor;
    assign nx         = (r_op == OP_INS_LEFT) ? r_anchor : r_key_succ;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(in_key);
        if (in_accept) begin
            rd_en = 1'b1;
        end else if (r_state == S_RDI) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_item);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_next   = r_res_next;
        n_res_prev   = r_res_prev;
        succ_we      = 1'b0;
        succ_waddr   = r_clr_cnt;
        succ_wdata   = '0;
        pred_we      = 1'b0;
        pred_waddr   = r_clr_cnt;
        pred_wdata   = '0;
        pres_we      = 1'b0;
        pres_waddr   = r_clr_cnt;
        pres_wdata   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                succ_we    = 1'b1;
                pred_we    = 1'b1;
                pres_we    = 1'b1;
                succ_wdata = (r_clr_cnt == '0) ? ID_W'(1) : '0;
                pred_wdata = (r_clr_cnt == '0) ? ID_W'(1) : '0;
                pres_wdata = (r_clr_cnt <= AW'(1));
                if (r_clr_cnt == AW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                n_state      = S_DONE;
                n_res_status = ST_OK;
                n_res_next   = '0;
                n_res_prev   = '0;
                unique case (r_op)
                    OP_FOLLOW: begin
                        if (!key_member) begin
                            n_res_status = ST_ANCHOR_ABSENT;
                        end else begin
                            n_res_next = r_key_succ;
                            n_res_prev = r_key_pred;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_item == '0) begin
                            n_res_status = ST_ITEM_ZERO;
                        end else if (!key_member) begin
                            n_res_status = ST_ITEM_ABSENT;
                        end else begin
                            n_res_next = r_key_succ;
                            n_res_prev = r_key_pred;
                            succ_we    = 1'b1;
                            succ_waddr = AW'(r_key_pred);
                            succ_wdata = r_key_succ;
                            pred_we    = 1'b1;
                            pred_waddr = AW'(r_key_succ);
                            pred_wdata = r_key_pred;
                            pres_we    = 1'b1;
                            pres_waddr = AW'(r_item);
                            pres_wdata = 1'b0;
                        end
                    end
                    OP_INS_LEFT, OP_INS_RIGHT: begin
                        if (r_item == '0 || !item_in) begin
                            n_res_status = ST_ITEM_ZERO;
                        end else if (!key_member) begin
                            n_res_status = ST_ANCHOR_ABSENT;
                        end else if (pres_q) begin
                            n_res_status = ST_ITEM_PRESENT;
                        end else begin
                            n_res_next = nx;
                            n_res_prev = pv;
                            succ_we    = 1'b1;
                            succ_waddr = AW'(r_item);
                            succ_wdata = nx;
                            pred_we    = 1'b1;
                            pred_waddr = AW'(r_item);
                            pred_wdata = pv;
                            pres_we    = 1'b1;
                            pres_waddr = AW'(r_item);
                            pres_wdata = 1'b1;
                            n_state    = S_WR2;
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_WR2: begin
                succ_we    = 1'b1;
                succ_waddr = AW'(pv);
                succ_wdata = r_item;
                pred_we    = 1'b1;
                pred_waddr = AW'(nx);
                pred_wdata = r_item;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= t_op'(i_operation);
            r_item   <= i_item_id;
            r_anchor <= i_anchor_id;
        end
        if (r_state == S_RDI) begin
            r_key_succ <= succ_q;
            r_key_pred <= pred_q;
            r_key_pres <= pres_q;
        end
        r_res_status <= n_res_status;
        r_res_next   <= n_res_next;
        r_res_prev   <= n_res_prev;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_next   <= r_res_next;
            r_out_prev   <= r_res_prev;
        end
    end

    idll_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (succ_we),
        .i_waddr (succ_waddr),
        .i_wdata (succ_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (succ_q)
    );

    idll_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (pred_we),
        .i_waddr (pred_waddr),
        .i_wdata (pred_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (pred_q)
    );

    idll_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (pres_waddr),
        .i_wdata (pres_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (pres_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_next_id   = r_out_next;
    assign o_prev_id   = r_out_prev;

endmodule

/* design/idll_checker.sv */
// Port-level checks for the indexed doubly linked list block, bound to the top.
// Depends on idll_pkg for status codes and field widths.
module idll_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [idll_pkg::ST_W-1:0] o_status,
    input logic [idll_pkg::ID_W-1:0] o_next_id,
    input logic [idll_pkg::ID_W-1:0] o_prev_id
);

    import idll_pkg::*;

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not stalled and empty after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_error_zero_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_next_id == '0) && (o_prev_id == '0))
        else $error("error result carries nonzero neighbour ids");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_ITEM_ZERO)
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_next_id) && $stable(o_prev_id))
        else $error("stalled result changed");

endmodule

bind indexed_doubly_linked_list_top idll_checker u_idll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_next_id   (o_next_id),
    .o_prev_id   (o_prev_id)
);
